// File: sv/ewms_pkg.sv
// Package for the mean-seeded exponential moving average block.
// Holds register codes, fixed field widths and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package ewms_pkg;

   // Configuration register widths and codes.
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned ALPHA_W     = 17;
   localparam int unsigned FRAC_BITS   = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP_LENGTH    = 2'd1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'h10000;
   localparam logic [COUNT_W-1:0] WARMUP_RESET = 11'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // take the request sample
      logic prep;      // load the divider from the running sum
      logic div_step;  // one restoring-division step
      logic fix;       // apply the sign to the quotient
      logic mul;       // register alpha times the difference
      logic add;       // add the scaled difference to the previous average
      logic finish;    // move the result into the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic warm_now;  // the next sample belongs to the warm-up mean
      logic div_last;  // the divider is on its final step
      logic out_free;  // the response register can take a new result
   } status_type;

endpackage

`default_nettype wire

// File: sv/ewms_req_if.sv
// Request channel interface: valid/ready handshake carrying one sample.
// Depends on nothing.
`default_nettype none

interface ewms_req_if #(
   parameter int SAMPLE_BITS = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// File: sv/ewms_rsp_if.sv
// Response channel interface: valid/ready handshake carrying the average
// and the warm-up flag. Depends on nothing.
`default_nettype none

interface ewms_rsp_if #(
   parameter int SAMPLE_BITS = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;
   logic                          warmed_up;

   modport source (output valid, output average, output warmed_up, input ready);
   modport sink   (input valid, input average, input warmed_up, output ready);
endinterface

`default_nettype wire

// File: sv/ewms_ctrl.sv
// Controller state machine for the moving average block.
// Uses ewms_pkg for the command and status structs.
`default_nettype none

module ewms_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ewms_pkg::status_type status,
   output ewms_pkg::cmd_type        cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_ADD  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.warm_now ? ST_PREP : ST_MUL;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold here while the previous result still waits downstream.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/ewms_dpath.sv
// Datapath for the moving average block: configuration registers, running
// sum and count, restoring divider, smoothing multiplier, response register.
// Uses ewms_pkg for widths, register codes and the command/status structs.
`default_nettype none

module ewms_dpath #(
   parameter int SAMPLE_BITS = 32,
   parameter int MAX_WARMUP  = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [ewms_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ewms_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  wire logic                                  rsp_ready,
   input  wire ewms_pkg::cmd_type                     cmd,
   output ewms_pkg::status_type                       status,
   output logic                                       rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]              rsp_average,
   output logic                                       rsp_warmed_up
);

   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WARMUP);
   localparam int STEP_W = $clog2(SUM_W);
   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int PROD_W = DIFF_W + ewms_pkg::ALPHA_W + 1;
   localparam int CW     = ewms_pkg::COUNT_W;

   // Configuration registers.
   logic [ewms_pkg::ALPHA_W-1:0] alpha_ff;
   logic [CW-1:0]                warmup_ff;

   // Algorithm state.
   logic signed [SUM_W-1:0]       sum_ff;
   logic [CW-1:0]                 seen_ff;
   logic signed [SAMPLE_BITS-1:0] cur_avg_ff;

   // Working registers.
   logic [SUM_W-1:0]              dq_ff;
   logic [CW:0]                   rem_ff;
   logic                          neg_ff;
   logic [STEP_W-1:0]             step_ff;
   logic signed [DIFF_W-1:0]      diff_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [SAMPLE_BITS-1:0] result_ff;

   // Response register.
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_avg_ff;
   logic                          rsp_warm_ff;

   logic [CW-1:0]                 eff_warmup;
   logic [ewms_pkg::ALPHA_W-1:0]  alpha_eff;
   logic signed [SUM_W-1:0]       sample_ext;
   logic [CW:0]                   rem_shift;
   logic                          rem_ge;
   logic signed [PROD_W-1:0]      prod_shift;
   logic signed [DIFF_W-1:0]      add_sum;
   logic [SAMPLE_BITS-1:0]        quot;

   always_comb begin
      eff_warmup = warmup_ff;
      if (warmup_ff == '0) begin
         eff_warmup = CW'(1);
      end else if (32'(warmup_ff) > 32'(MAX_WARMUP)) begin
         eff_warmup = CW'(MAX_WARMUP);
      end
      alpha_eff = (alpha_ff > ewms_pkg::ALPHA_ONE) ? ewms_pkg::ALPHA_ONE : alpha_ff;
   end

   assign sample_ext = SUM_W'(req_sample);
   assign rem_shift  = {rem_ff[CW-1:0], dq_ff[SUM_W-1]};
   assign rem_ge     = rem_shift >= {1'b0, seen_ff};
   // Arithmetic shift of the product rounds toward minus infinity.
   assign prod_shift = prod_ff >>> ewms_pkg::FRAC_BITS;
   assign add_sum    = DIFF_W'(cur_avg_ff) + prod_shift[DIFF_W-1:0];
   assign quot       = dq_ff[SAMPLE_BITS-1:0];

   assign status.warm_now = seen_ff < eff_warmup;
   assign status.div_last = step_ff == '0;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ewms_pkg::ALPHA_ONE;
         warmup_ff    <= ewms_pkg::WARMUP_RESET;
         sum_ff       <= '0;
         seen_ff      <= '0;
         cur_avg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ewms_pkg::CSR_SMOOTHING_FACTOR: alpha_ff  <= csr_wdata[ewms_pkg::ALPHA_W-1:0];
               ewms_pkg::CSR_WARMUP_LENGTH:    warmup_ff <= csr_wdata[CW-1:0];
               default: ;
            endcase
         end
         if (cmd.accept && status.warm_now) begin
            sum_ff  <= sum_ff + sample_ext;
            seen_ff <= seen_ff + CW'(1);
         end
         if (cmd.finish) begin
            cur_avg_ff   <= result_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         diff_ff <= DIFF_W'(req_sample) - DIFF_W'(cur_avg_ff);
      end
      if (cmd.prep) begin
         neg_ff  <= sum_ff[SUM_W-1];
         dq_ff   <= sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_ff  <= '0;
         step_ff <= STEP_W'(SUM_W - 1);
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_ge ? (rem_shift - {1'b0, seen_ff}) : rem_shift;
         dq_ff   <= {dq_ff[SUM_W-2:0], rem_ge};
         step_ff <= step_ff - STEP_W'(1);
      end
      if (cmd.fix) begin
         result_ff <= neg_ff ? SAMPLE_BITS'(-quot) : SAMPLE_BITS'(quot);
      end
      if (cmd.mul) begin
         prod_ff <= $signed({1'b0, alpha_eff}) * diff_ff;
      end
      if (cmd.add) begin
         result_ff <= add_sum[SAMPLE_BITS-1:0];
      end
      if (cmd.finish) begin
         rsp_avg_ff  <= result_ff;
         rsp_warm_ff <= seen_ff >= eff_warmup;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_average   = rsp_avg_ff;
   assign rsp_warmed_up = rsp_warm_ff;

endmodule

`default_nettype wire

// File: sv/ema_with_mean_seed.sv
// Exponential moving average seeded with an arithmetic mean: top level.
// Depends on ewms_pkg, ewms_req_if, ewms_rsp_if, ewms_ctrl and ewms_dpath.
// Usage: each transfer on req_chan carries one signed Q16.16 sample, and
// each produces exactly one transfer on rsp_chan with the new average and
// a flag that is set once the warm-up count has been reached. While the
// count of samples taken is below the warm-up length, the average is the
// running sum divided by that count, truncated toward zero. After that it
// is prev + alpha*(sample - prev), with the product rounded toward minus
// infinity at the Q1.16 point.
// Sequence: a warm-up sample runs through a restoring divider that retires
// one quotient bit per cycle over the SAMPLE_BITS+log2(MAX_WARMUP) bit
// sum, then the quotient gets its sign and moves into the response
// register. A smoothing sample needs one multiply and one add before it
// moves there. The next sample is taken only after the result has moved
// into the response register; one item is worked on at a time.
// The response register decouples the sides: a new sample is taken while
// the previous result still waits; only a finished second result waits
// for rsp_chan.ready. Reset (synchronous) sets alpha to 1.0, warm-up to 1,
// and clears the sum, the count, the average and rsp_chan.valid.
// Configuration writes via csr_we/csr_index/csr_wdata belong in idle time.
`default_nettype none

module ema_with_mean_seed #(
   parameter int SAMPLE_BITS = 32,
   parameter int MAX_WARMUP  = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   ewms_req_if.sink                              req_chan,
   ewms_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [ewms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ewms_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ewms_pkg::cmd_type    cmd;
   ewms_pkg::status_type status;
   logic                 req_ready;

   // The controller sequences one item at a time through the datapath.
   ewms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds all arithmetic, the state and the response register.
   ewms_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WARMUP  (MAX_WARMUP)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_sample    (req_chan.sample),
      .rsp_ready     (rsp_chan.ready),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_chan.valid),
      .rsp_average   (rsp_chan.average),
      .rsp_warmed_up (rsp_chan.warmed_up)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire
